FILE: sv/boxf_pkg.sv
// shared constants for the box filter smoothing block
// frame geometry, window limits and datapath widths; no dependencies
package boxf_pkg;

  localparam int FRAME_WIDTH  = 8;
  localparam int FRAME_HEIGHT = 8;
  localparam int PIX_TOTAL    = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int WIN_W   = 3;
  localparam int WIN_MAX = 7;
  localparam int WIN_RESET = 3;

  localparam int ACC_W  = $clog2(WIN_MAX * WIN_MAX * PIX_MAX + 1);
  localparam int DVS_W  = $clog2(WIN_MAX * WIN_MAX + 1);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT);
  localparam int COL_W  = $clog2(FRAME_WIDTH);
  localparam int ADDR_W = $clog2(PIX_TOTAL);
  localparam int CRD_W  = ((ROW_W > COL_W) ? ROW_W : COL_W) + WIN_W + 1;

endpackage

FILE: sv/boxf_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on boxf_pkg for the dividend and divisor widths
module boxf_div
  import boxf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [ACC_W-1:0] quotient
);

  localparam int CNT_W = $clog2(ACC_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [ACC_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial    = {rem, quo[ACC_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      quo <= {quo[ACC_W-2:0], ge};
      rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    end
  end

endmodule

FILE: sv/box_filter_mean_smoothing.sv
// Box filter smoothing of one 8x8 frame of 8-bit pixels. Pixels are taken in raster
// order into an internal frame store, one per cycle while s_axis_tready is high. When
// the last pixel of the frame arrives the block stops taking input and produces the
// whole smoothed frame in raster order, m_axis_tlast marking its final pixel. Each
// output is the sum over a square of side 2*(window_size/2)+1 centred on the pixel
// (edges clamped), divided by window_size^2, truncated and saturated at 255; a window
// size of zero acts as one, and saturation only bites for even sizes. Each output pixel
// is built in steps: one frame store read per window pixel into a single accumulator, a
// drain and a start state to finish the sum and start the divide, a shift-and-subtract
// divide, and the output state, which holds the pixel until the receiver takes it.
// window_size may only be written between frames.
// depends on boxf_pkg and boxf_div
module box_filter_mean_smoothing
  import boxf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [WIN_W-1:0] cfg_wdata,      // window_size
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [PIX_W-1:0] s_axis_tdata,   // pixel_in
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [PIX_W-1:0] m_axis_tdata,   // pixel_out
  output logic             m_axis_tlast    // last_out
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]        state;
  logic [WIN_W-1:0]  win_size;
  logic [ADDR_W-1:0] load_count;
  logic [ADDR_W-1:0] out_idx;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [WIN_W-1:0]  wr;
  logic [WIN_W-1:0]  wc;
  logic [ACC_W-1:0]  acc;
  logic              rd_pend;
  logic [PIX_W-1:0]  rd_data;
  logic [PIX_W-1:0]  frame_store [PIX_TOTAL];

  logic [WIN_W-1:0]  size_eff;
  logic [WIN_W-1:0]  span;
  logic [DVS_W-1:0]  divisor;
  logic [CRD_W-1:0]  crd_y;
  logic [CRD_W-1:0]  crd_x;
  logic [ROW_W-1:0]  y;
  logic [COL_W-1:0]  x;
  logic [ADDR_W-1:0] rd_addr;
  logic              in_req;
  logic              out_req;
  logic              div_done;
  logic [ACC_W-1:0]  quotient;

  assign size_eff = (win_size == '0) ? WIN_W'(1) : win_size;
  assign span     = {size_eff[WIN_W-1:1], 1'b0};
  assign divisor  = DVS_W'(size_eff) * DVS_W'(size_eff);

  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign out_req = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == ST_LOAD);
  assign m_axis_tvalid = (state == ST_OUT);

  // window coordinate, then clamp to the frame
  assign crd_y = CRD_W'(row) + CRD_W'(wr) - CRD_W'(size_eff[WIN_W-1:1]);
  assign crd_x = CRD_W'(col) + CRD_W'(wc) - CRD_W'(size_eff[WIN_W-1:1]);

  always_comb begin
    if (crd_y[CRD_W-1]) begin
      y = '0;
    end else if (crd_y > CRD_W'(FRAME_HEIGHT - 1)) begin
      y = ROW_W'(FRAME_HEIGHT - 1);
    end else begin
      y = crd_y[ROW_W-1:0];
    end
    if (crd_x[CRD_W-1]) begin
      x = '0;
    end else if (crd_x > CRD_W'(FRAME_WIDTH - 1)) begin
      x = COL_W'(FRAME_WIDTH - 1);
    end else begin
      x = crd_x[COL_W-1:0];
    end
  end

  assign rd_addr = ADDR_W'(y * FRAME_WIDTH + x);

  always_ff @(posedge clk) begin
    if (in_req) begin
      frame_store[load_count] <= s_axis_tdata;
    end
    if (state == ST_SUM) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  boxf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (acc),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= WIN_W'(WIN_RESET);
    end else if (cfg_wen) begin
      win_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      out_idx    <= '0;
      row        <= '0;
      col        <= '0;
      wr         <= '0;
      wc         <= '0;
      rd_pend    <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SUM);
      unique case (state)
        ST_LOAD: begin
          if (in_req) begin
            if (load_count == ADDR_W'(PIX_TOTAL - 1)) begin
              load_count <= '0;
              out_idx    <= '0;
              row        <= '0;
              col        <= '0;
              wr         <= '0;
              wc         <= '0;
              state      <= ST_SUM;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_SUM: begin
          if (wc == span) begin
            wc <= '0;
            if (wr == span) begin
              wr    <= '0;
              state <= ST_DRAIN;
            end else begin
              wr <= wr + 1'b1;
            end
          end else begin
            wc <= wc + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_req) begin
            if (m_axis_tlast) begin
              state <= ST_LOAD;
            end else begin
              out_idx <= out_idx + 1'b1;
              if (col == COL_W'(FRAME_WIDTH - 1)) begin
                col <= '0;
                row <= row + 1'b1;
              end else begin
                col <= col + 1'b1;
              end
              state <= ST_SUM;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // accumulator and result register
  always_ff @(posedge clk) begin
    if (state == ST_LOAD || state == ST_OUT) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc <= acc + ACC_W'(rd_data);
    end
    if (state == ST_DIV && div_done) begin
      m_axis_tdata <= (quotient > ACC_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : quotient[PIX_W-1:0];
      m_axis_tlast <= (out_idx == ADDR_W'(PIX_TOTAL - 1));
    end
  end

  a_ready_valid_excl : assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output handshakes open together");

  a_frame_end_reload : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not back to loading after the last output pixel");

  a_load_continues : assert property (@(posedge clk) disable iff (rst)
    (in_req && load_count != ADDR_W'(PIX_TOTAL - 1)) |=> s_axis_tready)
    else $error("loading stopped before the frame was complete");

  a_frame_start : assert property (@(posedge clk) disable iff (rst)
    (in_req && load_count == ADDR_W'(PIX_TOTAL - 1)) |=> (state == ST_SUM && out_idx == '0))
    else $error("output pass did not start at the first pixel");

endmodule
